### rtl/bog_pkg.sv
// Shared types and constants for the broadcast offset generator.
`timescale 1ns / 1ps
`default_nettype none

package bog_pkg;

    // Width of one axis size, stride or offset.
    localparam int LANE_W  = 16;
    // Register port: 64-bit data, registers at byte address 8*i.
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 6;
    // Width of the saturated result element count.
    localparam int COUNT_W = 32;

    // Control bits that travel with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic inr;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/bog_cfg.sv
// Register file and derivation sequencer for the broadcast result geometry.
`timescale 1ns / 1ps
`default_nettype none

module bog_cfg #(
    parameter int MAX_RANK = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [bog_pkg::ADDR_W-1:0]                 paddr,
    input  logic [bog_pkg::DATA_W-1:0]                 pwdata,
    output logic [bog_pkg::DATA_W-1:0]                 prdata,
    output logic                                       pready,
    output logic                                       o_idle,
    output logic                                       o_compat,
    output logic [bog_pkg::COUNT_W-1:0]                o_elem_count,
    output logic [MAX_RANK-1:0][bog_pkg::LANE_W-1:0]   o_res_stride,
    output logic [MAX_RANK-1:0][bog_pkg::LANE_W-1:0]   o_bs_a,
    output logic [MAX_RANK-1:0][bog_pkg::LANE_W-1:0]   o_bs_b
);
    import bog_pkg::*;

    localparam int RANK_W = $clog2(MAX_RANK + 1);
    localparam int POS_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    localparam logic [2:0] REG_RANK_A   = 3'd0;
    localparam logic [2:0] REG_RANK_B   = 3'd1;
    localparam logic [2:0] REG_SHAPE_A  = 3'd2;
    localparam logic [2:0] REG_SHAPE_B  = 3'd3;
    localparam logic [2:0] REG_STRIDE_A = 3'd4;
    localparam logic [2:0] REG_STRIDE_B = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SHAPE  = 3'b010,
        ST_STRIDE = 3'b100
    } t_seq_state;

    t_seq_state r_state, n_state;

    logic [2:0]        r_rank_a, r_rank_b;
    logic [DATA_W-1:0] r_shape_a, r_shape_b, r_stride_a, r_stride_b;

    logic [LANE_W-1:0]  r_res_shape  [MAX_RANK];
    logic [LANE_W-1:0]  r_res_stride [MAX_RANK];
    logic [LANE_W-1:0]  r_bs_a       [MAX_RANK];
    logic [LANE_W-1:0]  r_bs_b       [MAX_RANK];
    logic [LANE_W-1:0]  n_res_shape  [MAX_RANK];
    logic [LANE_W-1:0]  n_bs_a       [MAX_RANK];
    logic [LANE_W-1:0]  n_bs_b       [MAX_RANK];
    logic               r_compat, n_compat;
    logic [COUNT_W-1:0] r_acc;
    logic [POS_W-1:0]   r_pos;
    logic [RANK_W-1:0]  r_left;

    logic                      w_wr, w_known;
    logic [2:0]                w_idx;
    logic [RANK_W-1:0]         w_ra, w_rb, w_r;
    logic [LANE_W-1:0]         w_cur_shape;
    logic [COUNT_W+LANE_W-1:0] w_prod;
    logic [COUNT_W-1:0]        w_acc_next;

    function automatic logic [RANK_W-1:0] eff_rank(input logic [2:0] raw);
        logic [RANK_W-1:0] res;
        if (raw == 3'd0) begin
            res = RANK_W'(1);
        end else if (4'(raw) > 4'(MAX_RANK)) begin
            res = RANK_W'(MAX_RANK);
        end else begin
            res = RANK_W'(raw);
        end
        return res;
    endfunction

    // Only four lanes exist in a packed register; further axes take the default.
    function automatic logic [LANE_W-1:0] lane(input logic [DATA_W-1:0] word,
                                              input logic [3:0] axis,
                                              input logic [LANE_W-1:0] dflt);
        logic [LANE_W-1:0] res;
        if (axis > 4'd3) begin
            res = dflt;
        end else begin
            case (axis[1:0])
                2'd0:    res = word[15:0];
                2'd1:    res = word[31:16];
                2'd2:    res = word[47:32];
                2'd3:    res = word[63:48];
                default: res = dflt;
            endcase
        end
        return res;
    endfunction

    assign w_wr    = psel && penable && pwrite;
    assign w_idx   = paddr[ADDR_W-1:3];
    assign w_known = (w_idx == REG_RANK_A) || (w_idx == REG_RANK_B)
                  || (w_idx == REG_SHAPE_A) || (w_idx == REG_SHAPE_B)
                  || (w_idx == REG_STRIDE_A) || (w_idx == REG_STRIDE_B);
    assign pready  = 1'b1;

    always_comb begin
        case (w_idx)
            REG_RANK_A:   prdata = DATA_W'(r_rank_a);
            REG_RANK_B:   prdata = DATA_W'(r_rank_b);
            REG_SHAPE_A:  prdata = r_shape_a;
            REG_SHAPE_B:  prdata = r_shape_b;
            REG_STRIDE_A: prdata = r_stride_a;
            REG_STRIDE_B: prdata = r_stride_b;
            default:      prdata = '0;
        endcase
    end

    assign w_ra = eff_rank(r_rank_a);
    assign w_rb = eff_rank(r_rank_b);
    assign w_r  = (w_ra > w_rb) ? w_ra : w_rb;

    // Right-aligned pairing of the operand axes, one position per lane.
    always_comb begin
        logic [RANK_W-1:0] v_pos, v_off_a, v_off_b, v_ax_a, v_ax_b;
        logic [LANE_W-1:0] v_da, v_db;
        v_off_a  = w_r - w_ra;
        v_off_b  = w_r - w_rb;
        n_compat = 1'b1;
        for (int p = 0; p < MAX_RANK; p++) begin
            v_pos  = RANK_W'(p);
            v_ax_a = v_pos - v_off_a;
            v_ax_b = v_pos - v_off_b;
            v_da   = 16'd1;
            v_db   = 16'd1;
            n_bs_a[p] = '0;
            n_bs_b[p] = '0;
            if (v_pos < w_r) begin
                if (v_pos >= v_off_a) begin
                    v_da = lane(r_shape_a, 4'(v_ax_a), 16'd1);
                    if (v_da != 16'd1) begin
                        n_bs_a[p] = lane(r_stride_a, 4'(v_ax_a), 16'd0);
                    end
                end
                if (v_pos >= v_off_b) begin
                    v_db = lane(r_shape_b, 4'(v_ax_b), 16'd1);
                    if (v_db != 16'd1) begin
                        n_bs_b[p] = lane(r_stride_b, 4'(v_ax_b), 16'd0);
                    end
                end
                if (v_da != 16'd1 && v_db != 16'd1 && v_da != v_db) begin
                    n_compat = 1'b0;
                end
                n_res_shape[p] = (v_da == 16'd1) ? v_db : v_da;
            end else begin
                n_res_shape[p] = '0;
            end
        end
    end

    // One 32x16 multiply per step, saturating, innermost axis first.
    assign w_cur_shape = r_res_shape[r_pos];
    assign w_prod      = r_acc * w_cur_shape;
    assign w_acc_next  = (|w_prod[COUNT_W+LANE_W-1:COUNT_W]) ? '1 : w_prod[COUNT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   n_state = ST_IDLE;
            ST_SHAPE:  n_state = ST_STRIDE;
            ST_STRIDE: if (r_left == RANK_W'(1)) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_SHAPE;
        endcase
        if (w_wr && w_known) begin
            n_state = ST_SHAPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SHAPE;
            r_rank_a   <= 3'd1;
            r_rank_b   <= 3'd1;
            r_shape_a  <= DATA_W'(1);
            r_shape_b  <= DATA_W'(1);
            r_stride_a <= DATA_W'(1);
            r_stride_b <= DATA_W'(1);
            r_left     <= '0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                case (w_idx)
                    REG_RANK_A:   r_rank_a   <= pwdata[2:0];
                    REG_RANK_B:   r_rank_b   <= pwdata[2:0];
                    REG_SHAPE_A:  r_shape_a  <= pwdata;
                    REG_SHAPE_B:  r_shape_b  <= pwdata;
                    REG_STRIDE_A: r_stride_a <= pwdata;
                    REG_STRIDE_B: r_stride_b <= pwdata;
                    default:      r_rank_a   <= r_rank_a;
                endcase
            end
            if (r_state == ST_SHAPE) begin
                r_left <= w_r;
            end else if (r_state == ST_STRIDE) begin
                r_left <= r_left - RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SHAPE) begin
            r_compat <= n_compat;
            r_acc    <= COUNT_W'(1);
            r_pos    <= POS_W'(w_r - RANK_W'(1));
            for (int p = 0; p < MAX_RANK; p++) begin
                r_res_shape[p]  <= n_res_shape[p];
                r_res_stride[p] <= '0;
                r_bs_a[p]       <= n_bs_a[p];
                r_bs_b[p]       <= n_bs_b[p];
            end
        end else if (r_state == ST_STRIDE) begin
            r_res_stride[r_pos] <= (|r_acc[COUNT_W-1:LANE_W]) ? '1 : r_acc[LANE_W-1:0];
            r_acc               <= w_acc_next;
            r_pos               <= r_pos - POS_W'(1);
        end
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_compat     = r_compat;
    assign o_elem_count = r_acc;

    always_comb begin
        for (int p = 0; p < MAX_RANK; p++) begin
            o_res_stride[p] = r_res_stride[p];
            o_bs_a[p]       = r_bs_a[p];
            o_bs_b[p]       = r_bs_b[p];
        end
    end

`ifndef ASSERT_OFF
    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && w_known |=> r_state == ST_SHAPE)
        else $error("register write did not restart the derivation");

    a_stride_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STRIDE |-> r_left != '0)
        else $error("stride step with no axes left");

    a_stride_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STRIDE && r_left == RANK_W'(1) && !(w_wr && w_known)
        |=> r_state == ST_IDLE)
        else $error("derivation did not finish after the last axis");
`endif

endmodule

`default_nettype wire

### rtl/bog_axis.sv
// One result axis: pipelined restoring division by the axis stride and offset update.
`timescale 1ns / 1ps
`default_nettype none

module bog_axis #(
    parameter int INDEX_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  bog_pkg::t_ctl               i_ctl,
    input  logic [INDEX_BITS-1:0]       i_num,
    input  logic [bog_pkg::LANE_W-1:0]  i_acc_a,
    input  logic [bog_pkg::LANE_W-1:0]  i_acc_b,
    input  logic [bog_pkg::LANE_W-1:0]  i_stride,
    input  logic [bog_pkg::LANE_W-1:0]  i_bs_a,
    input  logic [bog_pkg::LANE_W-1:0]  i_bs_b,
    output bog_pkg::t_ctl               o_ctl,
    output logic [INDEX_BITS-1:0]       o_num,
    output logic [bog_pkg::LANE_W-1:0]  o_acc_a,
    output logic [bog_pkg::LANE_W-1:0]  o_acc_b
);
    import bog_pkg::*;

    localparam int STEPS = INDEX_BITS;

    t_ctl                  r_ctl   [STEPS];
    logic [INDEX_BITS-1:0] r_num   [STEPS];
    logic [LANE_W-1:0]     r_rem   [STEPS];
    logic [LANE_W-1:0]     r_acc_a [STEPS];
    logic [LANE_W-1:0]     r_acc_b [STEPS];
    t_ctl                  n_ctl   [STEPS];
    logic [INDEX_BITS-1:0] n_num   [STEPS];
    logic [LANE_W-1:0]     n_rem   [STEPS];
    logic [LANE_W-1:0]     n_acc_a [STEPS];
    logic [LANE_W-1:0]     n_acc_b [STEPS];

    t_ctl                  r_m_ctl;
    logic [INDEX_BITS-1:0] r_m_num;
    logic [LANE_W-1:0]     r_m_acc_a, r_m_acc_b;

    logic [LANE_W-1:0]     w_coef;
    logic [2*LANE_W-1:0]   w_prod_a, w_prod_b;

    // Each step brings down the top numerator bit and shifts a quotient bit
    // in at the bottom, so after the last step the word holds the quotient.
    always_comb begin
        t_ctl                  v_ctl;
        logic [INDEX_BITS-1:0] v_num;
        logic [LANE_W-1:0]     v_rem, v_a, v_b;
        logic [LANE_W:0]       v_sh, v_diff;
        logic                  v_ge;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                v_ctl = i_ctl;
                v_num = i_num;
                v_rem = '0;
                v_a   = i_acc_a;
                v_b   = i_acc_b;
            end else begin
                v_ctl = r_ctl[k-1];
                v_num = r_num[k-1];
                v_rem = r_rem[k-1];
                v_a   = r_acc_a[k-1];
                v_b   = r_acc_b[k-1];
            end
            v_sh       = {v_rem, v_num[INDEX_BITS-1]};
            v_diff     = v_sh - {1'b0, i_stride};
            v_ge       = (v_sh >= {1'b0, i_stride});
            n_ctl[k]   = v_ctl;
            n_num[k]   = {v_num[INDEX_BITS-2:0], v_ge};
            n_rem[k]   = v_ge ? v_diff[LANE_W-1:0] : v_sh[LANE_W-1:0];
            n_acc_a[k] = v_a;
            n_acc_b[k] = v_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) begin
                r_ctl[k] <= '0;
            end
            r_m_ctl <= '0;
        end else if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_ctl[k] <= n_ctl[k];
            end
            r_m_ctl <= r_ctl[STEPS-1];
        end
    end

    // Only the low 16 bits of the coordinate reach the wrapped offsets.
    assign w_coef   = LANE_W'(r_num[STEPS-1]);
    assign w_prod_a = w_coef * i_bs_a;
    assign w_prod_b = w_coef * i_bs_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_num[k]   <= n_num[k];
                r_rem[k]   <= n_rem[k];
                r_acc_a[k] <= n_acc_a[k];
                r_acc_b[k] <= n_acc_b[k];
            end
            r_m_num   <= INDEX_BITS'(r_rem[STEPS-1]);
            r_m_acc_a <= r_acc_a[STEPS-1] + w_prod_a[LANE_W-1:0];
            r_m_acc_b <= r_acc_b[STEPS-1] + w_prod_b[LANE_W-1:0];
        end
    end

    assign o_ctl   = r_m_ctl;
    assign o_num   = r_m_num;
    assign o_acc_a = r_m_acc_a;
    assign o_acc_b = r_m_acc_b;

endmodule

`default_nettype wire

### rtl/broadcast_offset_generator.sv
// Top level of the broadcast offset generator: register port, entry stage and axis pipeline.
//
//  Channel   Direction  Handshake                       Payload
//  input     in         i_in_valid / o_in_ready         i_out_index
//  result    out        o_out_valid / i_out_ready       o_offset_a, o_offset_b,
//                                                       o_in_range, o_shapes_ok
//  register  in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
//  One request enters per cycle while the result is not held and the geometry is idle;
//  the pipeline is an entry stage, then per axis restoring-division steps and a multiply stage.
//  After reset and after each write to a defined register the geometry is derived, one
//  multiply per axis; o_in_ready is low meanwhile.
//  A held result freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module broadcast_offset_generator #(
    parameter int MAX_RANK   = 4,
    parameter int INDEX_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_out_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bog_pkg::LANE_W-1:0]    o_offset_a,
    output logic [bog_pkg::LANE_W-1:0]    o_offset_b,
    output logic                          o_in_range,
    output logic                          o_shapes_ok,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bog_pkg::ADDR_W-1:0]    paddr,
    input  logic [bog_pkg::DATA_W-1:0]    pwdata,
    output logic [bog_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import bog_pkg::*;

    logic                             w_idle, w_compat, w_en, w_inr;
    logic [COUNT_W-1:0]               w_elem_count;
    logic [MAX_RANK-1:0][LANE_W-1:0]  w_res_stride, w_bs_a, w_bs_b;
    logic [INDEX_BITS-1:0]            w_idx;

    t_ctl                  r_ent_ctl;
    logic [INDEX_BITS-1:0] r_ent_num;

    t_ctl                  w_ctl   [MAX_RANK+1];
    logic [INDEX_BITS-1:0] w_num   [MAX_RANK+1];
    logic [LANE_W-1:0]     w_acc_a [MAX_RANK+1];
    logic [LANE_W-1:0]     w_acc_b [MAX_RANK+1];

    bog_cfg #(
        .MAX_RANK (MAX_RANK)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_idle       (w_idle),
        .o_compat     (w_compat),
        .o_elem_count (w_elem_count),
        .o_res_stride (w_res_stride),
        .o_bs_a       (w_bs_a),
        .o_bs_b       (w_bs_b)
    );

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en && w_idle;

    assign w_idx = INDEX_BITS'(i_out_index);
    assign w_inr = w_compat && (COUNT_W'(w_idx) < w_elem_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_ctl <= '0;
        end else if (w_en) begin
            r_ent_ctl.valid <= i_in_valid && o_in_ready;
            r_ent_ctl.inr   <= w_inr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ent_num <= w_idx;
        end
    end

    assign w_ctl[0]   = r_ent_ctl;
    assign w_num[0]   = r_ent_num;
    assign w_acc_a[0] = '0;
    assign w_acc_b[0] = '0;

    // Outermost axis first; the remainder of each axis feeds the next one.
    for (genvar g = 0; g < MAX_RANK; g++) begin : g_axis
        bog_axis #(
            .INDEX_BITS (INDEX_BITS)
        ) u_axis (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctl    (w_ctl[g]),
            .i_num    (w_num[g]),
            .i_acc_a  (w_acc_a[g]),
            .i_acc_b  (w_acc_b[g]),
            .i_stride (w_res_stride[g]),
            .i_bs_a   (w_bs_a[g]),
            .i_bs_b   (w_bs_b[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_num    (w_num[g+1]),
            .o_acc_a  (w_acc_a[g+1]),
            .o_acc_b  (w_acc_b[g+1])
        );
    end

    // Out-of-range and incompatible requests report zero offsets.
    assign o_out_valid = w_ctl[MAX_RANK].valid;
    assign o_in_range  = w_ctl[MAX_RANK].inr;
    assign o_offset_a  = w_acc_a[MAX_RANK] & {LANE_W{w_ctl[MAX_RANK].inr}};
    assign o_offset_b  = w_acc_b[MAX_RANK] & {LANE_W{w_ctl[MAX_RANK].inr}};
    assign o_shapes_ok = w_compat;

`ifndef ASSERT_OFF
    a_reset_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("request taken before the geometry was derived");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while the pipeline is frozen");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
        |=> r_ent_ctl.valid
            && (r_ent_ctl.inr == (w_compat && (COUNT_W'(r_ent_num) < w_elem_count))))
        else $error("entry stage range flag does not match the index");
`endif

endmodule

`default_nettype wire

### sim/bog_test_pkg.sv
// Register indexes and timing constants shared by the test bench files.
`timescale 1ns / 1ps

package bog_test_pkg;

    // Register order of the configuration port; byte address is 8 times the index.
    typedef enum logic [2:0] {
        REG_RANK_A   = 3'd0,
        REG_RANK_B   = 3'd1,
        REG_SHAPE_A  = 3'd2,
        REG_SHAPE_B  = 3'd3,
        REG_STRIDE_A = 3'd4,
        REG_STRIDE_B = 3'd5
    } t_reg_index;

    localparam int MAX_AXES    = 4;
    localparam int INDEX_W     = 16;
    localparam int PIPE_CYCLES = 1 + MAX_AXES * (INDEX_W + 1);

endpackage

### sim/broadcast_offset_generator_check.sv
// Checker that predicts and compares every offset result of the broadcast offset generator.
`timescale 1ns / 1ps

module broadcast_offset_generator_check
    import bog_pkg::*;
    import bog_test_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [15:0]       i_out_index,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [LANE_W-1:0] i_offset_a,
    input  logic [LANE_W-1:0] i_offset_b,
    input  logic              i_in_range,
    input  logic              i_shapes_ok,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [LANE_W-1:0] offset_a;
        logic [LANE_W-1:0] offset_b;
        logic              in_range;
        logic              shapes_ok;
    } t_offsets;

    t_offsets expected_offsets[$];
    int       mismatch_total = 0;
    int       result_total   = 0;
    int       request_total  = 0;

    // Shadow of the configuration registers.
    logic [2:0]        rank_a_q, rank_b_q;
    logic [DATA_W-1:0] shape_a_q, shape_b_q, stride_a_q, stride_b_q;

    // Geometry derived from the shadow registers.
    int unsigned       geo_rank;
    logic [LANE_W-1:0] axis_stride [MAX_AXES];
    logic [LANE_W-1:0] a_step [MAX_AXES];
    logic [LANE_W-1:0] b_step [MAX_AXES];
    longint unsigned   elem_total;
    bit                shapes_compatible;

    function automatic int unsigned clamp_rank(logic [2:0] raw);
        if (raw == 3'd0) return 1;
        if (raw > MAX_AXES) return MAX_AXES;
        return raw;
    endfunction

    function automatic void derive_geometry();
        int unsigned       ra, rb, pos, lane_a, lane_b;
        logic [LANE_W-1:0] da, db;
        logic [LANE_W-1:0] res_size [MAX_AXES];
        longint unsigned   acc;
        ra = clamp_rank(rank_a_q);
        rb = clamp_rank(rank_b_q);
        geo_rank = (ra > rb) ? ra : rb;
        shapes_compatible = 1'b1;
        acc = 1;
        for (int k = 0; k < MAX_AXES; k++) begin
            res_size[k]    = '0;
            axis_stride[k] = '0;
            a_step[k]      = '0;
            b_step[k]      = '0;
        end
        // Axes are paired from the innermost one; a missing axis acts as size one.
        for (int i = 0; i < geo_rank; i++) begin
            pos    = geo_rank - 1 - i;
            lane_a = ra - 1 - i;
            lane_b = rb - 1 - i;
            da = (i < ra) ? shape_a_q[16*lane_a +: 16] : 16'd1;
            db = (i < rb) ? shape_b_q[16*lane_b +: 16] : 16'd1;
            if (da != 16'd1 && db != 16'd1 && da != db) shapes_compatible = 1'b0;
            res_size[pos] = (da == 16'd1) ? db : da;
            a_step[pos] = (i < ra && da != 16'd1) ? stride_a_q[16*lane_a +: 16] : 16'd0;
            b_step[pos] = (i < rb && db != 16'd1) ? stride_b_q[16*lane_b +: 16] : 16'd0;
        end
        for (int i = 0; i < geo_rank; i++) begin
            pos = geo_rank - 1 - i;
            axis_stride[pos] = (acc > 64'hFFFF) ? 16'hFFFF : 16'(acc);
            acc = acc * res_size[pos];
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        end
        elem_total = acc;
    endfunction

    function automatic t_offsets predict_offsets(logic [15:0] idx);
        t_offsets        res;
        longint unsigned rest, coord, sum_a, sum_b;
        sum_a = 0;
        sum_b = 0;
        res.in_range  = shapes_compatible && (idx < elem_total);
        res.shapes_ok = shapes_compatible;
        if (res.in_range) begin
            rest = idx;
            for (int i = 0; i < geo_rank; i++) begin
                if (axis_stride[i] != 16'd0) begin
                    coord = rest / axis_stride[i];
                    rest  = rest % axis_stride[i];
                    sum_a = sum_a + coord * a_step[i];
                    sum_b = sum_b + coord * b_step[i];
                end
            end
        end
        res.offset_a = 16'(sum_a);
        res.offset_b = 16'(sum_b);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_offsets want, got;
        if (!i_rst_n) begin
            rank_a_q   = 3'd1;
            rank_b_q   = 3'd1;
            shape_a_q  = 64'd1;
            shape_b_q  = 64'd1;
            stride_a_q = 64'd1;
            stride_b_q = 64'd1;
            derive_geometry();
            expected_offsets.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_offsets.push_back(predict_offsets(i_out_index));
                request_total++;
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_offset_a, i_offset_b, i_in_range, i_shapes_ok};
                if (expected_offsets.size() == 0) begin
                    if (mismatch_total < 10)
                        $display("result a=%h b=%h range=%b ok=%b with no request outstanding",
                                 got.offset_a, got.offset_b, got.in_range, got.shapes_ok);
                    mismatch_total++;
                end else begin
                    want = expected_offsets.pop_front();
                    if (got !== want) begin
                        if (mismatch_total < 10)
                            $display("result %0d: expected %h %h %b %b, got %h %h %b %b",
                                     result_total,
                                     want.offset_a, want.offset_b, want.in_range,
                                     want.shapes_ok, got.offset_a, got.offset_b,
                                     got.in_range, got.shapes_ok);
                        mismatch_total++;
                    end
                    result_total++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_index'(i_paddr[ADDR_W-1:3]))
                    REG_RANK_A:   rank_a_q   = i_pwdata[2:0];
                    REG_RANK_B:   rank_b_q   = i_pwdata[2:0];
                    REG_SHAPE_A:  shape_a_q  = i_pwdata;
                    REG_SHAPE_B:  shape_b_q  = i_pwdata;
                    REG_STRIDE_A: stride_a_q = i_pwdata;
                    REG_STRIDE_B: stride_b_q = i_pwdata;
                    default: ;
                endcase
                derive_geometry();
            end
        end
        o_pending    <= expected_offsets.size();
        o_fail_count <= mismatch_total;
        o_checked    <= result_total;
    end

endmodule

### sim/broadcast_offset_generator_test.sv
// Top of the broadcast offset generator test bench: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module broadcast_offset_generator_test;
    import bog_pkg::*;
    import bog_test_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 600;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [15:0]       i_out_index;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [LANE_W-1:0] o_offset_a;
    logic [LANE_W-1:0] o_offset_b;
    logic              o_in_range;
    logic              o_shapes_ok;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int          fail_count, pending_count, checked_count;
    int          cycle_count   = 0;
    int          offered_total = 0;
    int          config_count  = 0;
    int          burst_left    = 0;
    int unsigned index_span;
    bit          long_hold_req  = 1'b0;
    bit          long_hold_done = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    broadcast_offset_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_index (i_out_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_offset_a  (o_offset_a),
        .o_offset_b  (o_offset_b),
        .o_in_range  (o_in_range),
        .o_shapes_ok (o_shapes_ok),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    broadcast_offset_generator_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_out_index  (i_out_index),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_offset_a   (o_offset_a),
        .i_offset_b   (o_offset_b),
        .i_in_range   (o_in_range),
        .i_shapes_ok  (o_shapes_ok),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    // Entered and left on a falling edge.
    task automatic write_reg(input t_reg_index idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic [DATA_W-1:0] rank_a, input logic [DATA_W-1:0] rank_b,
                                input logic [DATA_W-1:0] shape_a, input logic [DATA_W-1:0] shape_b,
                                input logic [DATA_W-1:0] stride_a,
                                input logic [DATA_W-1:0] stride_b);
        write_reg(REG_RANK_A, rank_a);
        write_reg(REG_RANK_B, rank_b);
        write_reg(REG_SHAPE_A, shape_a);
        write_reg(REG_SHAPE_B, shape_b);
        write_reg(REG_STRIDE_A, stride_a);
        write_reg(REG_STRIDE_B, stride_b);
        config_count++;
    endtask

    // Offers one request; requests go out in bursts separated by random gaps.
    task automatic offer_index(input logic [15:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid  <= 1'b0;
                i_out_index <= 16'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_out_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        offered_total++;
    endtask

    // Lowers valid and waits until every request of the phase has its result.
    task automatic end_phase();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Builds mostly compatible shapes, small enough that indices reach every axis.
    task automatic load_random_config();
        logic [2:0]        raw_a, raw_b;
        int unsigned       eff_a, eff_b, res_r, a_size, b_size, spoil;
        logic [DATA_W-1:0] shp_a, shp_b, str_a, str_b, word_a, word_b;
        logic [LANE_W-1:0] res_size [MAX_AXES];
        raw_a = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        raw_b = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        eff_a = (raw_a == 3'd0) ? 1 : (raw_a > MAX_AXES) ? MAX_AXES : raw_a;
        eff_b = (raw_b == 3'd0) ? 1 : (raw_b > MAX_AXES) ? MAX_AXES : raw_b;
        res_r = (eff_a > eff_b) ? eff_a : eff_b;
        shp_a = {$urandom, $urandom};
        shp_b = {$urandom, $urandom};
        str_a = {$urandom, $urandom};
        str_b = {$urandom, $urandom};
        for (int k = 0; k < MAX_AXES; k++) res_size[k] = 16'($urandom_range(1, 6));
        // Each operand axis either matches the result axis or is broadcast from size one.
        for (int k = 0; k < eff_a; k++) begin
            shp_a[16*k +: 16] = ($urandom_range(0, 2) == 0) ? 16'd1 : res_size[res_r - eff_a + k];
            str_a[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 40));
        end
        for (int k = 0; k < eff_b; k++) begin
            shp_b[16*k +: 16] = ($urandom_range(0, 2) == 0) ? 16'd1 : res_size[res_r - eff_b + k];
            str_b[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 40));
        end
        index_span = 1;
        for (int p = 0; p < res_r; p++) begin
            a_size = (p >= res_r - eff_a) ? shp_a[16*(p - (res_r - eff_a)) +: 16] : 1;
            b_size = (p >= res_r - eff_b) ? shp_b[16*(p - (res_r - eff_b)) +: 16] : 1;
            index_span = index_span * ((a_size == 1) ? b_size : a_size);
        end
        // Now and then one axis is spoilt, giving incompatible or empty shapes.
        if ($urandom_range(0, 7) == 0) begin
            spoil = $urandom_range(0, eff_a - 1);
            shp_a[16*spoil +: 16] = 16'($urandom_range(0, 8));
        end
        word_a = {$urandom, $urandom};
        word_b = {$urandom, $urandom};
        word_a[2:0] = raw_a;
        word_b[2:0] = raw_b;
        write_config(word_a, word_b, shp_a, shp_b, str_a, str_b);
    endtask

    function automatic logic [15:0] pick_index(input int unsigned span);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0 || span == 0) return 16'($urandom);
        if (sel == 1) return 16'(span);
        return 16'($urandom_range(0, span - 1));
    endfunction

    // Receiver: stall patterns of its own, and one long hold-off on request.
    initial begin : receiver
        int          seg_left;
        t_stall_mode mode;
        seg_left    = 0;
        mode        = STALL_NONE;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_done = 1'b1;
            end
            if (seg_left == 0) begin
                mode     = t_stall_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (mode)
                STALL_NONE:     i_out_ready <= 1'b1;
                STALL_HALF:     i_out_ready <= 1'($urandom_range(0, 1));
                STALL_HEAVY:    i_out_ready <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_out_ready <= ((seg_left % 3) != 0);
                default:        i_out_ready <= 1'b1;
            endcase
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("broadcast_offset_generator_test: FAIL");
        $finish;
    end

    initial begin : stimulus
        int random_sent, count;
        bit hold_phase;
        random_sent = 0;
        hold_phase  = 1'b1;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_index = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Geometry after reset is a single element.
        offer_index(16'd0);
        offer_index(16'd1);
        offer_index(16'hFFFF);
        end_phase();

        // Full rank on both sides, with size-one axes on B.
        write_config(64'd4, 64'd4, {16'd5, 16'd4, 16'd3, 16'd2}, {16'd5, 16'd1, 16'd3, 16'd1},
                     {16'd1, 16'd5, 16'd20, 16'd60}, {16'd1, 16'h1234, 16'd5, 16'hFFFF});
        offer_index(16'd0);
        offer_index(16'd119);
        offer_index(16'd120);
        offer_index(16'd60);
        offer_index(16'hFFFF);
        end_phase();

        // Rank zero acts as one, rank seven saturates; unused lanes carry junk.
        write_config(64'hFFFF_FFFF_FFFF_FFF8, 64'hA5A5_0000_0000_0007,
                     {16'hBEEF, 16'h0000, 16'hFFFF, 16'd6}, {16'd6, 16'd3, 16'd1, 16'd2},
                     {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3}, {16'd1, 16'd6, 16'd99, 16'd18});
        offer_index(16'd0);
        offer_index(16'd35);
        offer_index(16'd36);
        offer_index(16'd20);
        end_phase();

        // Sizes three and four cannot be broadcast together.
        write_config(64'd1, 64'd1, {48'd0, 16'd3}, {48'd0, 16'd4}, 64'd1, 64'd1);
        offer_index(16'd0);
        offer_index(16'd2);
        end_phase();

        // Size one against size zero gives an empty result.
        write_config(64'd1, 64'd1, 64'd1, 64'd0, 64'd7, 64'd9);
        offer_index(16'd0);
        offer_index(16'hFFFF);
        end_phase();

        // Large strides make the offsets wrap.
        write_config(64'd2, 64'd2, {32'd0, 16'd256, 16'd256}, {32'd0, 16'd1, 16'd256},
                     {32'd0, 16'hFFFF, 16'hFFFF}, {32'd0, 16'd7, 16'h8000});
        offer_index(16'hFFFF);
        offer_index(16'd65283);
        offer_index(16'd12345);
        end_phase();

        // Largest sizes: the element count and the result strides saturate.
        write_config(64'd4, 64'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_index(16'hFFFF);
        offer_index(16'd0);
        offer_index(16'd32768);
        offer_index(16'($urandom));
        end_phase();

        // Random settings; the first phase is long and meets the receiver's hold-off.
        while (random_sent < RANDOM_REQUESTS) begin
            load_random_config();
            count = hold_phase ? 160 : $urandom_range(8, 40);
            if (hold_phase) long_hold_req = 1'b1;
            hold_phase = 1'b0;
            repeat (count) offer_index(pick_index(index_span));
            random_sent += count;
            end_phase();
        end

        repeat (PIPE_CYCLES + 16) @(negedge i_clk);
        $display("Covered %0d requests over %0d register settings; %0d results compared.",
                 offered_total, config_count + 1, checked_count);
        $display("The receiver held off once for %0d cycles while requests kept coming.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending_count == 0) begin
            $display("broadcast_offset_generator_test: PASS");
        end else begin
            $display("broadcast_offset_generator_test: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bog_pkg.sv
rtl/bog_cfg.sv
rtl/bog_axis.sv
rtl/broadcast_offset_generator.sv
sim/bog_test_pkg.sv
sim/broadcast_offset_generator_check.sv
sim/broadcast_offset_generator_test.sv
